// ----- src/mmmv_pkg.sv -----
// ============================================================================
// mmmv_pkg
// Shared types and constants for the windowed min/max/mean/variance core.
// ============================================================================
package mmmv_pkg;

    // Payload widths fixed by the item formats
    localparam int SAMPLE_W  = 16;
    localparam int VAR_W     = 31;
    localparam int CHAN_W    = 3;
    localparam int LEN_W     = 6;
    localparam int SUM_W     = 21;
    localparam int SUMSQ_W   = 37;
    localparam int EX_W      = 33;
    localparam int SQ_W      = 33;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Variance saturation point (1.0 at scale 2^-30)
    localparam logic [EX_W-1:0] VAR_LIMIT = EX_W'(33'h0_4000_0000);

    // Shift-subtract divider: one quotient bit per cycle over the widest dividend
    localparam int DIV_STEPS = SUMSQ_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = LEN_W + 1;

    // Depth of the closed-window queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 1'b0,
        CFG_MERGE_MODE    = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_SUM,
        BK_DIV_SQ,
        BK_SQUARE,
        BK_RESULT
    } t_back_state;

    // One input request
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] in_min;
        logic signed [SAMPLE_W-1:0] in_max;
        logic        [VAR_W-1:0]    in_var;
        logic                       last;
    } t_in_item;

    // One result request
    typedef struct packed {
        logic        [CHAN_W-1:0]   channel;
        logic signed [SAMPLE_W-1:0] out_min;
        logic signed [SAMPLE_W-1:0] out_max;
        logic signed [SAMPLE_W-1:0] out_mean;
        logic        [VAR_W-1:0]    out_var;
        logic        [LEN_W-1:0]    window_len;
    } t_out_item;

    // Raw totals of one closed window, front to back
    typedef struct packed {
        logic        [CHAN_W-1:0]   channel;
        logic signed [SAMPLE_W-1:0] run_min;
        logic signed [SAMPLE_W-1:0] run_max;
        logic signed [SUM_W-1:0]    run_sum;
        logic        [SUMSQ_W-1:0]  run_sumsq;
        logic        [LEN_W-1:0]    len;
    } t_win_rec;

endpackage

// ----- src/mmmv_front.sv -----
// ============================================================================
// mmmv_front
// Channel sequencing and per-channel running min/max/sum/sum-of-squares.
// Closes a window on a full count or a last flag and emits its totals.
// ============================================================================
module mmmv_front #(
    parameter int WINDOW       = 32,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mmmv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mmmv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    input  mmmv_pkg::t_in_item             i_item,
    input  logic                           i_q_full,
    output logic                           o_rec_push,
    output mmmv_pkg::t_win_rec             o_rec
);
    import mmmv_pkg::*;

    localparam int CI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CFG_DATA_W-1:0]      r_chan_cnt;
    logic                       r_merge;
    logic [CI_W-1:0]            r_chan;
    logic [LEN_W-1:0]           r_fill  [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] r_min   [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] r_max   [MAX_CHANNELS];
    logic signed [SUM_W-1:0]    r_sum   [MAX_CHANNELS];
    logic [SUMSQ_W-1:0]         r_sumsq [MAX_CHANNELS];

    logic [CFG_DATA_W-1:0]      w_cc;
    logic [CI_W-1:0]            w_c;
    logic [CI_W-1:0]            w_c_next;
    logic                       w_accept;
    logic signed [31:0]         w_prod;
    logic [SQ_W-1:0]            w_sq;
    logic signed [SAMPLE_W-1:0] w_lo;
    logic signed [SAMPLE_W-1:0] w_hi;
    logic                       w_first;
    logic signed [SAMPLE_W-1:0] w_min_new;
    logic signed [SAMPLE_W-1:0] w_max_new;
    logic signed [SUM_W-1:0]    w_sum_new;
    logic [SUMSQ_W-1:0]         w_sumsq_new;
    logic [LEN_W-1:0]           w_fill_new;
    logic                       w_close;

    // Effective channel count and current channel
    always_comb begin
        if (r_chan_cnt == '0) begin
            w_cc = CFG_DATA_W'(1);
        end else if (r_chan_cnt > CFG_DATA_W'(MAX_CHANNELS)) begin
            w_cc = CFG_DATA_W'(MAX_CHANNELS);
        end else begin
            w_cc = r_chan_cnt;
        end
        w_c      = (CFG_DATA_W'(r_chan) >= w_cc) ? '0 : r_chan;
        w_c_next = ((CFG_DATA_W'(w_c) + CFG_DATA_W'(1)) >= w_cc) ? '0 : CI_W'(w_c + CI_W'(1));
    end

    assign w_accept = i_push && !i_q_full;

    // Item contribution: raw sample or merged record
    assign w_prod = i_item.value * i_item.value;
    always_comb begin
        if (r_merge) begin
            w_lo = i_item.in_min;
            w_hi = i_item.in_max;
            w_sq = SQ_W'(w_prod[30:0]) + SQ_W'(i_item.in_var);
        end else begin
            w_lo = i_item.value;
            w_hi = i_item.value;
            w_sq = SQ_W'(w_prod[30:0]);
        end
    end

    // Running totals after this item
    always_comb begin
        w_first = (r_fill[w_c] == '0);
        if (w_first) begin
            w_min_new   = w_lo;
            w_max_new   = w_hi;
            w_sum_new   = SUM_W'(i_item.value);
            w_sumsq_new = SUMSQ_W'(w_sq);
        end else begin
            w_min_new   = (w_lo < r_min[w_c]) ? w_lo : r_min[w_c];
            w_max_new   = (w_hi > r_max[w_c]) ? w_hi : r_max[w_c];
            w_sum_new   = r_sum[w_c] + SUM_W'(i_item.value);
            w_sumsq_new = r_sumsq[w_c] + SUMSQ_W'(w_sq);
        end
        w_fill_new = r_fill[w_c] + LEN_W'(1);
        w_close    = (w_fill_new >= LEN_W'(WINDOW)) || i_item.last;
    end

    // Configuration, channel pointer and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= CFG_DATA_W'(1);
            r_merge    <= 1'b0;
            r_chan     <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_CHANNEL_COUNT: r_chan_cnt <= i_cfg_data;
                    CFG_MERGE_MODE:    r_merge    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_chan      <= w_c_next;
                r_fill[w_c] <= w_close ? '0 : w_fill_new;
            end
        end
    end

    // Accumulator payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_min[w_c]   <= w_min_new;
            r_max[w_c]   <= w_max_new;
            r_sum[w_c]   <= w_sum_new;
            r_sumsq[w_c] <= w_sumsq_new;
        end
    end

    // Closed window totals
    assign o_rec_push      = w_accept && w_close;
    assign o_rec.channel   = CHAN_W'(w_c);
    assign o_rec.run_min   = w_min_new;
    assign o_rec.run_max   = w_max_new;
    assign o_rec.run_sum   = w_sum_new;
    assign o_rec.run_sumsq = w_sumsq_new;
    assign o_rec.len       = w_fill_new;

endmodule

// ----- src/mmmv_queue.sv -----
// ============================================================================
// mmmv_queue
// Short register queue of closed-window totals between front and back.
// ============================================================================
module mmmv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mmmv_pkg::t_win_rec i_rec,
    output logic               o_full,
    input  logic               i_take,
    output logic               o_valid,
    output mmmv_pkg::t_win_rec o_rec
);
    import mmmv_pkg::*;

    t_win_rec          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_do_push;
    logic              w_do_take;

    assign o_full    = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rec     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_take = i_take && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_do_take) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_do_push, w_do_take})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ----- src/mmmv_back.sv -----
// ============================================================================
// mmmv_back
// Turns window totals into mean and variance with a shared bit-serial
// divider, then holds the result in an output register.
// ============================================================================
module mmmv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rec_valid,
    input  mmmv_pkg::t_win_rec i_rec,
    output logic               o_rec_take,
    input  logic               i_pop,
    output logic               o_empty,
    output mmmv_pkg::t_out_item o_result
);
    import mmmv_pkg::*;

    t_back_state                r_state;
    t_back_state                n_state;

    logic [CHAN_W-1:0]          r_channel;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic [SUMSQ_W-1:0]         r_sumsq;
    logic [LEN_W-1:0]           r_len;
    logic                       r_neg;
    logic [SUMSQ_W-1:0]         r_div;
    logic [REM_W-1:0]           r_rem;
    logic [DIV_CNT_W-1:0]       r_cnt;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [VAR_W-1:0]           r_m2;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic [SUM_W-1:0]           w_abs;
    logic [SUMSQ_W-1:0]         w_num;
    logic [REM_W-1:0]           w_trial;
    logic                       w_qbit;
    logic [REM_W-1:0]           w_rem_next;
    logic [SUMSQ_W-1:0]         w_div_next;
    logic                       w_last_step;
    logic [SAMPLE_W-1:0]        w_q16;
    logic signed [31:0]         w_sq;
    logic [EX_W-1:0]            w_diff;
    logic [EX_W-1:0]            w_var;
    logic                       w_slot_free;

    // Floor division of a negative sum: divide |sum| + M - 1, then negate
    always_comb begin
        w_abs = i_rec.run_sum[SUM_W-1] ? SUM_W'(-i_rec.run_sum) : SUM_W'(i_rec.run_sum);
        w_num = SUMSQ_W'(w_abs);
        if (i_rec.run_sum[SUM_W-1]) begin
            w_num = w_num + SUMSQ_W'(i_rec.len) - SUMSQ_W'(1);
        end
    end

    // One shift-subtract step
    always_comb begin
        w_trial     = {r_rem[REM_W-2:0], r_div[SUMSQ_W-1]};
        w_qbit      = (w_trial >= REM_W'(r_len));
        w_rem_next  = w_qbit ? (w_trial - REM_W'(r_len)) : w_trial;
        w_div_next  = {r_div[SUMSQ_W-2:0], w_qbit};
        w_last_step = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        w_q16       = w_div_next[SAMPLE_W-1:0];
    end

    // Mean squared and clamped variance
    assign w_sq = r_mean * r_mean;
    always_comb begin
        w_diff = r_div[EX_W-1:0] - EX_W'(r_m2);
        if (r_div[EX_W-1:0] <= EX_W'(r_m2)) begin
            w_var = '0;
        end else if (w_diff > VAR_LIMIT) begin
            w_var = VAR_LIMIT;
        end else begin
            w_var = w_diff;
        end
    end

    assign w_slot_free = !r_out_valid || i_pop;

    // Next state
    always_comb begin
        n_state    = r_state;
        o_rec_take = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_rec_valid) begin
                    o_rec_take = 1'b1;
                    n_state    = BK_DIV_SUM;
                end
            end
            BK_DIV_SUM: begin
                if (w_last_step) begin
                    n_state = BK_DIV_SQ;
                end
            end
            BK_DIV_SQ: begin
                if (w_last_step) begin
                    n_state = BK_SQUARE;
                end
            end
            BK_SQUARE: begin
                n_state = BK_RESULT;
            end
            BK_RESULT: begin
                if (w_slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_RESULT && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (i_rec_valid) begin
                    r_channel <= i_rec.channel;
                    r_min     <= i_rec.run_min;
                    r_max     <= i_rec.run_max;
                    r_sumsq   <= i_rec.run_sumsq;
                    r_len     <= i_rec.len;
                    r_neg     <= i_rec.run_sum[SUM_W-1];
                    r_div     <= w_num;
                    r_rem     <= '0;
                    r_cnt     <= '0;
                end
            end
            BK_DIV_SUM: begin
                if (w_last_step) begin
                    r_mean <= r_neg ? SAMPLE_W'(SAMPLE_W'(0) - w_q16) : w_q16;
                    r_div  <= r_sumsq;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_div <= w_div_next;
                    r_rem <= w_rem_next;
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                end
            end
            BK_DIV_SQ: begin
                r_div <= w_div_next;
                r_rem <= w_rem_next;
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            BK_SQUARE: begin
                r_m2 <= w_sq[VAR_W-1:0];
            end
            BK_RESULT: begin
                if (w_slot_free) begin
                    r_out.channel    <= r_channel;
                    r_out.out_min    <= r_min;
                    r_out.out_max    <= r_max;
                    r_out.out_mean   <= r_mean;
                    r_out.out_var    <= VAR_W'(w_var);
                    r_out.window_len <= r_len;
                end
            end
            default: ;
        endcase
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ----- src/block_min_max_mean_variance_core.sv -----
// ============================================================================
// block_min_max_mean_variance_core
// Windowed per-channel min / max / mean / variance decimator.
// ============================================================================
//
//  Channel   Handshake         Payload
//  -------   ---------------   ------------------------------------------
//  input     i_push / o_full   i_item   (value, in_min, in_max, in_var, last)
//  result    o_empty / i_pop   o_result (channel, min, max, mean, var, len)
//  config    i_cfg_we          i_cfg_idx, i_cfg_data
//
//  The front accumulates one item per cycle while the window queue has room.
//  The back works on one closed window at a time: it takes the totals, runs
//  two divisions (mean, then mean of squares) in one shared shift-subtract
//  divider, squares the mean, then loads the result once the output is free.
//  Two closed windows can wait in the queue; o_full rises when both are held.
//  Reset is synchronous and leaves all channel windows empty.
//
module block_min_max_mean_variance_core #(
    parameter int WINDOW       = 32,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mmmv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mmmv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_push,
    output logic                            o_full,
    input  mmmv_pkg::t_in_item              i_item,
    output logic                            o_empty,
    input  logic                            i_pop,
    output mmmv_pkg::t_out_item             o_result
);
    import mmmv_pkg::*;

    logic     w_rec_push;
    t_win_rec w_rec_in;
    logic     w_q_full;
    logic     w_q_valid;
    t_win_rec w_q_rec;
    logic     w_q_take;

    // Accumulation front
    mmmv_front #(
        .WINDOW       (WINDOW),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_q_full   (w_q_full),
        .o_rec_push (w_rec_push),
        .o_rec      (w_rec_in)
    );

    // Closed-window queue
    mmmv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_rec   (w_rec_in),
        .o_full  (w_q_full),
        .i_take  (w_q_take),
        .o_valid (w_q_valid),
        .o_rec   (w_q_rec)
    );

    // Statistics back end
    mmmv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (w_q_valid),
        .i_rec       (w_q_rec),
        .o_rec_take  (w_q_take),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result)
    );

    assign o_full = w_q_full;

endmodule

// ----- src/mmmv_checker.sv -----
// ============================================================================
// mmmv_checker
// Port-level checks on the min/max/mean/variance core, bound to the top.
// ============================================================================
module mmmv_checker #(
    parameter int WINDOW = 32
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_empty,
    input logic                i_pop,
    input mmmv_pkg::t_out_item o_result
);
    import mmmv_pkg::*;

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result pending after reset");

    // A result not taken stays put
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("result changed while stalled");

    // Window length within one window
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_result.window_len != '0 &&
                      o_result.window_len <= LEN_W'(WINDOW)))
        else $error("window length out of range");

    // Variance saturates at one
    a_var_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (EX_W'(o_result.out_var) <= VAR_LIMIT))
        else $error("variance above limit");

endmodule

bind block_min_max_mean_variance_core mmmv_checker #(
    .WINDOW (WINDOW)
) u_mmmv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_empty  (o_empty),
    .i_pop    (i_pop),
    .o_result (o_result)
);
